>>> src/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants and types for the button and switch debouncer.
// ----------------------------------------------------------------------------
package bsd_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int SETTLE_BITS        = 16;
   localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 16'd500;

   localparam int NUM_BUTTONS  = 3;
   localparam int NUM_SWITCHES = 2;

   // button lane order
   localparam int BTN_JOYSTICK = 0;
   localparam int BTN_A        = 1;
   localparam int BTN_B        = 2;
   // switch lane order
   localparam int SW_LINK = 0;
   localparam int SW_MODE = 1;

   typedef enum logic [3:0] {
      BTN_IDLE   = 4'b0001,
      BTN_SETTLE = 4'b0010,
      BTN_PRIMED = 4'b0100,
      BTN_EVENT  = 4'b1000
   } button_phase_type;

   // what the lanes found on one tick, handed to the merge stage
   typedef struct packed {
      logic [NUM_BUTTONS-1:0]  click;
      logic [NUM_SWITCHES-1:0] level;
      logic                    link_prev;
   } lane_result_type;

endpackage

>>> src/bsd_button_lane.sv
// ----------------------------------------------------------------------------
// bsd_button_lane
// One push button: idle, settle, primed, event, with a saturating timer.
// ----------------------------------------------------------------------------
module bsd_button_lane #(
   parameter int TIMER_BITS = bsd_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            pin,
   input  logic [bsd_pkg::SETTLE_BITS-1:0] settle_ticks,
   output logic                            click
);

   localparam int CMP_BITS =
      (TIMER_BITS > bsd_pkg::SETTLE_BITS) ? TIMER_BITS : bsd_pkg::SETTLE_BITS;

   bsd_pkg::button_phase_type phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [TIMER_BITS-1:0] timer_bump;
   logic                  expired;

   assign timer_bump = (timer_ff == {TIMER_BITS{1'b1}}) ? timer_ff
                                                         : timer_ff + TIMER_BITS'(1);
   assign expired = CMP_BITS'(timer_bump) > CMP_BITS'(settle_ticks);

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      click    = 1'b0;
      case (phase_ff)
         bsd_pkg::BTN_IDLE: begin
            if (!pin) begin
               timer_in = '0;
               phase_in = bsd_pkg::BTN_SETTLE;
            end
         end
         bsd_pkg::BTN_SETTLE: begin
            timer_in = timer_bump;
            if (expired) begin
               phase_in = pin ? bsd_pkg::BTN_IDLE : bsd_pkg::BTN_PRIMED;
            end
         end
         bsd_pkg::BTN_PRIMED: begin
            if (pin) begin
               phase_in = bsd_pkg::BTN_EVENT;
            end
         end
         bsd_pkg::BTN_EVENT: begin
            click    = 1'b1;
            phase_in = bsd_pkg::BTN_IDLE;
         end
         default: begin
            phase_in = bsd_pkg::BTN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bsd_pkg::BTN_IDLE;
         timer_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
      end
   end

endmodule

>>> src/bsd_switch_lane.sv
// ----------------------------------------------------------------------------
// bsd_switch_lane
// One toggle switch: stable level, re-sampled once a change has settled.
// ----------------------------------------------------------------------------
module bsd_switch_lane #(
   parameter int TIMER_BITS = bsd_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            pin,
   input  logic [bsd_pkg::SETTLE_BITS-1:0] settle_ticks,
   output logic                            level_prev,
   output logic                            level_next
);

   localparam int CMP_BITS =
      (TIMER_BITS > bsd_pkg::SETTLE_BITS) ? TIMER_BITS : bsd_pkg::SETTLE_BITS;

   logic                  settling_ff, settling_in;
   logic                  level_ff, level_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [TIMER_BITS-1:0] timer_bump;
   logic                  expired;

   assign timer_bump = (timer_ff == {TIMER_BITS{1'b1}}) ? timer_ff
                                                         : timer_ff + TIMER_BITS'(1);
   assign expired = CMP_BITS'(timer_bump) > CMP_BITS'(settle_ticks);

   always_comb begin
      settling_in = settling_ff;
      level_in    = level_ff;
      timer_in    = timer_ff;
      if (!settling_ff) begin
         if (pin != level_ff) begin
            timer_in    = '0;
            settling_in = 1'b1;
         end
      end else begin
         timer_in = timer_bump;
         if (expired) begin
            // new level is whatever the pin shows now
            level_in    = pin;
            settling_in = 1'b0;
         end
      end
   end

   assign level_prev = level_ff;
   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         settling_ff <= 1'b0;
         level_ff    <= 1'b1;
         timer_ff    <= '0;
      end else if (advance) begin
         settling_ff <= settling_in;
         level_ff    <= level_in;
         timer_ff    <= timer_in;
      end
   end

endmodule

>>> src/bsd_merge.sv
// ----------------------------------------------------------------------------
// bsd_merge
// Combines lane results, gates A/B clicks by the prior link level and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module bsd_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  bsd_pkg::lane_result_type lanes,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic                     rsp_stick_click,
   output logic                     rsp_a_click,
   output logic                     rsp_b_click,
   output logic                     rsp_link_on,
   output logic                     rsp_joystick_mode
);

   logic valid_ff;
   logic stick_ff, a_ff, b_ff, link_ff, mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stick_ff <= lanes.click[bsd_pkg::BTN_JOYSTICK];
         a_ff     <= lanes.click[bsd_pkg::BTN_A] & lanes.link_prev;
         b_ff     <= lanes.click[bsd_pkg::BTN_B] & lanes.link_prev;
         link_ff  <= lanes.level[bsd_pkg::SW_LINK];
         mode_ff  <= lanes.level[bsd_pkg::SW_MODE];
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_stick_click   = stick_ff;
   assign rsp_a_click       = a_ff;
   assign rsp_b_click       = b_ff;
   assign rsp_link_on       = link_ff;
   assign rsp_joystick_mode = mode_ff;

endmodule

>>> src/button_switch_debouncer_core.sv
// ----------------------------------------------------------------------------
// button_switch_debouncer_core
// Debounces three push buttons and two toggle switches, one tick per
// transaction, with a lane per pin and a registered merge stage.
// ----------------------------------------------------------------------------
//  channel   ports                               direction
//  req       req_valid/req_stall + 5 pin levels  in
//  rsp       rsp_valid/rsp_stall + 5 result bits out
//  csr       csr_wr_en/csr_wr_data (settle_ticks) in
//
// One tick per clock while req_stall is low; a result appears in the output
// register in the cycle after acceptance. req_stall follows rsp_stall only
// while it is full, so a drained result lets the next tick in the same cycle.
// Reset is synchronous; settle_ticks returns to 500, all lanes idle/stable.
// ----------------------------------------------------------------------------
module button_switch_debouncer_core #(
   parameter int TIMER_BITS = bsd_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_stick_pin,
   input  logic                            req_a_pin,
   input  logic                            req_b_pin,
   input  logic                            req_link_pin,
   input  logic                            req_mode_pin,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_stick_click,
   output logic                            rsp_a_click,
   output logic                            rsp_b_click,
   output logic                            rsp_link_on,
   output logic                            rsp_joystick_mode,
   input  logic                            csr_wr_en,
   input  logic [bsd_pkg::SETTLE_BITS-1:0] csr_wr_data
);

   logic [bsd_pkg::SETTLE_BITS-1:0] settle_ticks_ff;
   logic                            advance;
   logic [bsd_pkg::NUM_BUTTONS-1:0]  btn_pin;
   logic [bsd_pkg::NUM_SWITCHES-1:0] sw_pin;
   logic [bsd_pkg::NUM_SWITCHES-1:0] sw_prev;
   bsd_pkg::lane_result_type         lanes;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= bsd_pkg::SETTLE_RESET;
      end else if (csr_wr_en) begin
         settle_ticks_ff <= csr_wr_data;
      end
   end

   assign req_stall = rsp_valid & rsp_stall;
   assign advance   = req_valid & ~req_stall;

   assign btn_pin[bsd_pkg::BTN_JOYSTICK] = req_stick_pin;
   assign btn_pin[bsd_pkg::BTN_A]        = req_a_pin;
   assign btn_pin[bsd_pkg::BTN_B]        = req_b_pin;
   assign sw_pin[bsd_pkg::SW_LINK]       = req_link_pin;
   assign sw_pin[bsd_pkg::SW_MODE]       = req_mode_pin;

   for (genvar i = 0; i < bsd_pkg::NUM_BUTTONS; i++) begin : g_btn
      bsd_button_lane #(.TIMER_BITS(TIMER_BITS)) u_lane (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .pin          (btn_pin[i]),
         .settle_ticks (settle_ticks_ff),
         .click        (lanes.click[i])
      );
   end

   for (genvar i = 0; i < bsd_pkg::NUM_SWITCHES; i++) begin : g_sw
      bsd_switch_lane #(.TIMER_BITS(TIMER_BITS)) u_lane (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .pin          (sw_pin[i]),
         .settle_ticks (settle_ticks_ff),
         .level_prev   (sw_prev[i]),
         .level_next   (lanes.level[i])
      );
   end

   assign lanes.link_prev = sw_prev[bsd_pkg::SW_LINK];

   bsd_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .lanes             (lanes),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stick_click   (rsp_stick_click),
      .rsp_a_click       (rsp_a_click),
      .rsp_b_click       (rsp_b_click),
      .rsp_link_on       (rsp_link_on),
      .rsp_joystick_mode (rsp_joystick_mode)
   );

endmodule

>>> src/bsd_checker.sv
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level checks for button_switch_debouncer_core, bound to the top level.
// ----------------------------------------------------------------------------
module bsd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_stick_click,
   input logic rsp_a_click,
   input logic rsp_b_click,
   input logic rsp_link_on,
   input logic rsp_joystick_mode
);

   // every accepted transaction leaves a result behind
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // a delivered result with nothing new accepted empties the output
   a_no_duplicate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !(req_valid && !req_stall)) |=> !rsp_valid)
      else $error("result repeated");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_stick_click)
         && $stable(rsp_a_click) && $stable(rsp_b_click)
         && $stable(rsp_link_on) && $stable(rsp_joystick_mode)))
      else $error("stalled result changed");

endmodule

bind button_switch_debouncer_core bsd_checker u_bsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_stick_click   (rsp_stick_click),
   .rsp_a_click       (rsp_a_click),
   .rsp_b_click       (rsp_b_click),
   .rsp_link_on       (rsp_link_on),
   .rsp_joystick_mode (rsp_joystick_mode)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for button_switch_debouncer_core. Pin ticks go in
// through a valid/stall sender. A debounce model held here predicts the click
// and switch outputs of every tick, and each result is checked field by field.
// The settle window is swept across several values: the reset value, zero and
// the saturating top value.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TB_TIMER_BITS = bsd_pkg::TIMER_BITS_DEFAULT;
   localparam int SB            = bsd_pkg::SETTLE_BITS;

   typedef struct packed {
      logic stick;
      logic a;
      logic b;
      logic link;
      logic mode;
   } pin_tick_type;

   typedef struct packed {
      logic stick_click;
      logic a_click;
      logic b_click;
      logic link_on;
      logic joystick_mode;
   } debounce_out_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_stick_pin;
   logic          req_a_pin;
   logic          req_b_pin;
   logic          req_link_pin;
   logic          req_mode_pin;
   logic          rsp_valid;
   logic          rsp_stall;
   logic          rsp_stick_click;
   logic          rsp_a_click;
   logic          rsp_b_click;
   logic          rsp_link_on;
   logic          rsp_joystick_mode;
   logic          csr_wr_en;
   logic [SB-1:0] csr_wr_data;

   // debounce model state
   logic [SB-1:0]              settle_window;
   bsd_pkg::button_phase_type  btn_phase [bsd_pkg::NUM_BUTTONS];
   logic [TB_TIMER_BITS-1:0]   btn_timer [bsd_pkg::NUM_BUTTONS];
   logic                       sw_settling [bsd_pkg::NUM_SWITCHES];
   logic [TB_TIMER_BITS-1:0]   sw_timer [bsd_pkg::NUM_SWITCHES];
   logic                       sw_level [bsd_pkg::NUM_SWITCHES];

   debounce_out_type debounced_q[$];

   int  error_count;
   int  ticks_sent;
   int  clicks_seen;
   int  windows_used;
   int  stall_left;
   bit  quiet;

   button_switch_debouncer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stick_pin     (req_stick_pin),
      .req_a_pin         (req_a_pin),
      .req_b_pin         (req_b_pin),
      .req_link_pin      (req_link_pin),
      .req_mode_pin      (req_mode_pin),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_stick_click   (rsp_stick_click),
      .rsp_a_click       (rsp_a_click),
      .rsp_b_click       (rsp_b_click),
      .rsp_link_on       (rsp_link_on),
      .rsp_joystick_mode (rsp_joystick_mode),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic void model_reset();
      settle_window = bsd_pkg::SETTLE_RESET;
      for (int k = 0; k < bsd_pkg::NUM_BUTTONS; k++) begin
         btn_phase[k] = bsd_pkg::BTN_IDLE;
         btn_timer[k] = '0;
      end
      for (int k = 0; k < bsd_pkg::NUM_SWITCHES; k++) begin
         sw_settling[k] = 1'b0;
         sw_timer[k]    = '0;
         sw_level[k]    = 1'b1;
      end
   endfunction

   function automatic logic button_step(int k, logic pin);
      logic click;
      click = 1'b0;
      case (btn_phase[k])
         bsd_pkg::BTN_IDLE: begin
            if (!pin) begin
               btn_timer[k] = '0;
               btn_phase[k] = bsd_pkg::BTN_SETTLE;
            end
         end
         bsd_pkg::BTN_SETTLE: begin
            if (btn_timer[k] != '1) btn_timer[k] = btn_timer[k] + 1'b1;
            if (btn_timer[k] > settle_window)
               btn_phase[k] = pin ? bsd_pkg::BTN_IDLE : bsd_pkg::BTN_PRIMED;
         end
         bsd_pkg::BTN_PRIMED: begin
            if (pin) btn_phase[k] = bsd_pkg::BTN_EVENT;
         end
         default: begin
            click        = 1'b1;
            btn_phase[k] = bsd_pkg::BTN_IDLE;
         end
      endcase
      return click;
   endfunction

   function automatic void switch_step(int k, logic pin);
      if (!sw_settling[k]) begin
         if (pin != sw_level[k]) begin
            sw_timer[k]    = '0;
            sw_settling[k] = 1'b1;
         end
      end else begin
         if (sw_timer[k] != '1) sw_timer[k] = sw_timer[k] + 1'b1;
         // new level is whatever the pin reads now
         if (sw_timer[k] > settle_window) begin
            sw_level[k]    = pin;
            sw_settling[k] = 1'b0;
         end
      end
   endfunction

   function automatic debounce_out_type debounce_tick(pin_tick_type t);
      debounce_out_type o;
      logic             link_held;
      link_held       = sw_level[bsd_pkg::SW_LINK];
      o.stick_click   = button_step(bsd_pkg::BTN_JOYSTICK, t.stick);
      o.a_click       = button_step(bsd_pkg::BTN_A, t.a) & link_held;
      o.b_click       = button_step(bsd_pkg::BTN_B, t.b) & link_held;
      switch_step(bsd_pkg::SW_LINK, t.link);
      switch_step(bsd_pkg::SW_MODE, t.mode);
      o.link_on       = sw_level[bsd_pkg::SW_LINK];
      o.joystick_mode = sw_level[bsd_pkg::SW_MODE];
      return o;
   endfunction

   // -------------------------------------------------------------- checking
   task automatic report_mismatch(string what, logic want, logic got);
      $display("[%0t] mismatch %s: expected %0b got %0b", $realtime, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      debounce_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         clicks_seen += rsp_stick_click + rsp_a_click + rsp_b_click;
         if (debounced_q.size() == 0) begin
            report_mismatch("unexpected transaction", 1'b0, 1'b1);
         end else begin
            want = debounced_q.pop_front();
            if (rsp_stick_click !== want.stick_click)
               report_mismatch("stick_click", want.stick_click, rsp_stick_click);
            if (rsp_a_click !== want.a_click)
               report_mismatch("a_click", want.a_click, rsp_a_click);
            if (rsp_b_click !== want.b_click)
               report_mismatch("b_click", want.b_click, rsp_b_click);
            if (rsp_link_on !== want.link_on)
               report_mismatch("link_on", want.link_on, rsp_link_on);
            if (rsp_joystick_mode !== want.joystick_mode)
               report_mismatch("joystick_mode", want.joystick_mode, rsp_joystick_mode);
         end
      end
   end

   // receiver stalls in short bursts
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
      end
   end

   // -------------------------------------------------------------- drivers
   task automatic send_tick(pin_tick_type t);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_stick_pin <= t.stick;
      req_a_pin     <= t.a;
      req_b_pin     <= t.b;
      req_link_pin  <= t.link;
      req_mode_pin  <= t.mode;
      do @(posedge clock); while (req_stall);
      debounced_q.push_back(debounce_tick(t));
      ticks_sent++;
   endtask

   task automatic send_repeat(pin_tick_type t, int n);
      repeat (n) send_tick(t);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (debounced_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_settle(logic [SB-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      settle_window = value;
      windows_used++;
   endtask

   // random pin traffic: mostly held levels around the window, some glitches
   task automatic send_random(int n);
      logic [4:0]    level;
      int            left [5];
      pin_tick_type  t;
      int            span;
      level = '1;
      for (int c = 0; c < 5; c++) left[c] = 0;
      // wide windows would never resolve inside a phase; keep hold times short
      span = (settle_window > 16) ? 16 : settle_window;
      repeat (n) begin
         for (int c = 0; c < 5; c++) begin
            if (left[c] == 0) begin
               level[c] = ~level[c];
               if ($urandom_range(0, 9) < 2) left[c] = $urandom_range(1, 2);
               else left[c] = span + $urandom_range(1, 4);
            end
            left[c]--;
         end
         if ($urandom_range(0, 9) == 0) t = pin_tick_type'(5'($urandom_range(0, 31)));
         else t = pin_tick_type'(level);
         send_tick(t);
      end
   endtask

   // ---------------------------------------------------------------- tests
   // reset window of 500: long press on everything, then release
   task automatic test_reset_window();
      send_repeat('0, 503);
      send_repeat('1, 4);
      drain();
   endtask

   task automatic test_directed();
      write_settle('0);
      send_tick('1);
      send_repeat('0, 3);
      send_repeat('1, 3);
      send_repeat(5'b01010, 3);
      send_repeat(5'b10101, 3);
      drain();
      // glitch shorter than the window returns the button to idle
      write_settle(16'd2);
      send_repeat(5'b01111, 1);
      send_repeat('1, 4);
      drain();
      // link switched off, then A and B click: clicks are suppressed
      write_settle(16'd1);
      send_repeat(5'b11101, 3);
      send_repeat(5'b10001, 3);
      send_repeat(5'b11101, 3);
      drain();
   endtask

   // top window: the timers can never exceed it, so no press or change settles
   task automatic test_saturated_window();
      write_settle('1);
      send_repeat('0, 4);
      send_random(40);
      drain();
   endtask

   task automatic test_random_windows();
      logic [SB-1:0] windows [5];
      windows = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd5};
      windows[3] = SB'($urandom_range(2, 10));
      for (int p = 0; p < 5; p++) begin
         if (p == 4) quiet = 1'b1;
         write_settle(windows[p]);
         send_random(270);
         drain();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_stick_pin = 1'b1;
      req_a_pin     = 1'b1;
      req_b_pin     = 1'b1;
      req_link_pin  = 1'b1;
      req_mode_pin  = 1'b1;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      quiet         = 1'b0;
      stall_left    = 0;
      error_count   = 0;
      ticks_sent    = 0;
      clicks_seen   = 0;
      windows_used  = 1;
      model_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_directed();
      test_saturated_window();
      test_random_windows();

      repeat (8) @(posedge clock);
      if (debounced_q.size() != 0)
         report_mismatch("results never delivered", 1'b0, 1'b1);
      $display("covered %0d ticks under %0d settle windows (0, 500 and 65535 included)",
               ticks_sent, windows_used);
      $display("observed %0d clicks, %0d mismatches", clicks_seen, error_count);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
src/bsd_pkg.sv
src/bsd_button_lane.sv
src/bsd_switch_lane.sv
src/bsd_merge.sv
src/button_switch_debouncer_core.sv
src/bsd_checker.sv
bench/testbench.sv
